// ----- design/segment_segment_distance_core_macros.svh -----
// Assertion helpers for the checker file ssd_chk.sv.
`ifndef SEGMENT_SEGMENT_DISTANCE_CORE_MACROS_SVH
`define SEGMENT_SEGMENT_DISTANCE_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int PARAM_W    = FRAC_BITS + 1;
	localparam int DIST_W     = 34;
	localparam int DIST_SHIFT = 2 * FRAC_BITS - 8;
	localparam int THR_W      = 21;
	localparam int APB_DW     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-3:0]  REG_DET_THR = '0;
	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1);
	localparam logic [PARAM_W-1:0] Q_ONE       = PARAM_W'(65536);
	localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

	typedef enum logic [1:0] {
		FR_ZERO,
		FR_ONE,
		FR_DIV
	} frac_kind_t;
endpackage
`default_nettype wire

// ----- design/ssd_frac_div.sv -----
`default_nettype none
module ssd_frac_div #(
	parameter int W  = 54,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	output logic [QW-1:0] quo
);
	// one restoring step per stage, num < den assumed
	logic [W-1:0]  rem_s [QW];
	logic [W-1:0]  den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [W-1:0]  r_in;
		logic [W-1:0]  d_in;
		logic [QW-1:0] q_in;
		logic [W:0]    sh;
		logic          take;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = quo_s[j-1];
		end

		assign sh   = {r_in, 1'b0};
		assign take = sh >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? W'(sh - {1'b0, d_in}) : W'(sh);
				den_s[j] <= d_in;
				quo_s[j] <= {q_in[QW-2:0], take};
			end
		end
	end

	assign quo = quo_s[QW-1];
endmodule
`default_nettype wire

// ----- design/segment_segment_distance_core.sv -----
// An accepted input word passes through the registered stages, the divider in the middle, to its result word.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// The depth is set by the 17-stage restoring divider for the clamped parameters.
// Reset: arst_n clears all valid bits and loads det_threshold with 1.
`default_nettype none
module segment_segment_distance_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssd_pkg::ADDR_W-1:0]        paddr,
	input  logic [ssd_pkg::APB_DW-1:0]        pwdata,
	output logic [ssd_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COORD_BITS-1:0]      first_start_x,
	input  logic signed [COORD_BITS-1:0]      first_start_y,
	input  logic signed [COORD_BITS-1:0]      first_start_z,
	input  logic signed [COORD_BITS-1:0]      first_end_x,
	input  logic signed [COORD_BITS-1:0]      first_end_y,
	input  logic signed [COORD_BITS-1:0]      first_end_z,
	input  logic signed [COORD_BITS-1:0]      second_start_x,
	input  logic signed [COORD_BITS-1:0]      second_start_y,
	input  logic signed [COORD_BITS-1:0]      second_start_z,
	input  logic signed [COORD_BITS-1:0]      second_end_x,
	input  logic signed [COORD_BITS-1:0]      second_end_y,
	input  logic signed [COORD_BITS-1:0]      second_end_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ssd_pkg::DIST_W-1:0]        dist_squared,
	output logic [ssd_pkg::PARAM_W-1:0]       param_first,
	output logic [ssd_pkg::PARAM_W-1:0]       param_second,
	output logic                              parallel
);
	import ssd_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int AW   = 2 * CW + 3;
	localparam int MW   = 2 * AW;
	localparam int NW   = MW + 1;
	localparam int UW   = NW - 1;
	localparam int SPW  = PARAM_W + 1 + DW;
	localparam int RW   = CW + 19;
	localparam int SQW  = 2 * RW;
	localparam int SUMW = SQW + 2;
	localparam int SHW  = SUMW - DIST_SHIFT;
	localparam int CMPW = (SHW > DIST_W) ? SHW : DIST_W;

	localparam logic signed [NW-1:0] N_ZERO = '0;
	localparam logic signed [NW-1:0] N_ONE  = NW'(1);

	typedef struct packed {
		logic [2:0][DW-1:0] k;
		logic [2:0][DW-1:0] d0;
		logic [2:0][DW-1:0] d1;
	} geo_t;

	typedef struct packed {
		geo_t       geo;
		logic       par;
		frac_kind_t ks;
		frac_kind_t kt;
	} side_t;

	// configuration
	logic [THR_W-1:0] thr_q;
	logic             cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = paddr[ADDR_W-1:2] == REG_DET_THR;
	assign prdata  = cfg_hit ? APB_DW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s25, v_s26, v_s27, v_s28, v_s29;
	logic vld_d [PARAM_W];

	assign adv       = !(v_s29 && out_stall);
	assign in_stall  = !adv;
	assign out_valid = v_s29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s25 <= 1'b0;
			v_s26 <= 1'b0;
			v_s27 <= 1'b0;
			v_s28 <= 1'b0;
			v_s29 <= 1'b0;
			for (int j = 0; j < PARAM_W; j++) vld_d[j] <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			vld_d[0] <= v_s7;
			for (int j = 1; j < PARAM_W; j++) vld_d[j] <= vld_d[j-1];
			v_s25 <= vld_d[PARAM_W-1];
			v_s26 <= v_s25;
			v_s27 <= v_s26;
			v_s28 <= v_s27;
			v_s29 <= v_s28;
		end
	end

	// s1: edge and offset vectors
	logic signed [CW-1:0] p0 [3];
	logic signed [CW-1:0] p1 [3];
	logic signed [CW-1:0] q0 [3];
	logic signed [CW-1:0] q1 [3];
	geo_t geo_s1;

	assign p0[0] = first_start_x;
	assign p0[1] = first_start_y;
	assign p0[2] = first_start_z;
	assign p1[0] = first_end_x;
	assign p1[1] = first_end_y;
	assign p1[2] = first_end_z;
	assign q0[0] = second_start_x;
	assign q0[1] = second_start_y;
	assign q0[2] = second_start_z;
	assign q1[0] = second_end_x;
	assign q1[1] = second_end_y;
	assign q1[2] = second_end_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				geo_s1.d0[i] <= DW'(p1[i]) - DW'(p0[i]);
				geo_s1.d1[i] <= DW'(q1[i]) - DW'(q0[i]);
				geo_s1.k[i]  <= DW'(p0[i]) - DW'(q0[i]);
			end
		end
	end

	// s2: per-axis products
	logic signed [PW-1:0] aa_s2 [3];
	logic signed [PW-1:0] ab_s2 [3];
	logic signed [PW-1:0] bb_s2 [3];
	logic signed [PW-1:0] kd0_s2 [3];
	logic signed [PW-1:0] kd1_s2 [3];
	geo_t geo_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				aa_s2[i]  <= signed'(geo_s1.d0[i]) * signed'(geo_s1.d0[i]);
				ab_s2[i]  <= signed'(geo_s1.d0[i]) * signed'(geo_s1.d1[i]);
				bb_s2[i]  <= signed'(geo_s1.d1[i]) * signed'(geo_s1.d1[i]);
				kd0_s2[i] <= signed'(geo_s1.k[i]) * signed'(geo_s1.d0[i]);
				kd1_s2[i] <= signed'(geo_s1.k[i]) * signed'(geo_s1.d1[i]);
			end
			geo_s2 <= geo_s1;
		end
	end

	// s3: dot products
	logic signed [AW-1:0] a00_s3, a01_s3, a11_s3, b0_s3, b1_s3;
	geo_t geo_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a00_s3 <= AW'(aa_s2[0]) + AW'(aa_s2[1]) + AW'(aa_s2[2]);
			a01_s3 <= -(AW'(ab_s2[0]) + AW'(ab_s2[1]) + AW'(ab_s2[2]));
			a11_s3 <= AW'(bb_s2[0]) + AW'(bb_s2[1]) + AW'(bb_s2[2]);
			b0_s3  <= AW'(kd0_s2[0]) + AW'(kd0_s2[1]) + AW'(kd0_s2[2]);
			b1_s3  <= -(AW'(kd1_s2[0]) + AW'(kd1_s2[1]) + AW'(kd1_s2[2]));
			geo_s3 <= geo_s2;
		end
	end

	// s4: cross products
	logic signed [MW-1:0] m_a00a11_s4, m_a01sq_s4, m_a01b1_s4, m_a11b0_s4, m_a01b0_s4, m_a00b1_s4;
	logic signed [AW-1:0] a00_s4, a01_s4, a11_s4, b0_s4, b1_s4;
	geo_t geo_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_a00a11_s4 <= a00_s3 * a11_s3;
			m_a01sq_s4  <= a01_s3 * a01_s3;
			m_a01b1_s4  <= a01_s3 * b1_s3;
			m_a11b0_s4  <= a11_s3 * b0_s3;
			m_a01b0_s4  <= a01_s3 * b0_s3;
			m_a00b1_s4  <= a00_s3 * b1_s3;
			a00_s4      <= a00_s3;
			a01_s4      <= a01_s3;
			a11_s4      <= a11_s3;
			b0_s4       <= b0_s3;
			b1_s4       <= b1_s3;
			geo_s4      <= geo_s3;
		end
	end

	// s5: determinant and unclamped numerators
	logic signed [NW-1:0] det_s5, sn_s5, tn_s5;
	logic signed [AW-1:0] a00_s5, a01_s5, a11_s5, b0_s5, b1_s5;
	geo_t geo_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5 <= NW'(m_a00a11_s4) - NW'(m_a01sq_s4);
			sn_s5  <= NW'(m_a01b1_s4) - NW'(m_a11b0_s4);
			tn_s5  <= NW'(m_a01b0_s4) - NW'(m_a00b1_s4);
			a00_s5 <= a00_s4;
			a01_s5 <= a01_s4;
			a11_s5 <= a11_s4;
			b0_s5  <= b0_s4;
			b1_s5  <= b1_s4;
			geo_s5 <= geo_s4;
		end
	end

	// s6: region classification, pick ratio operands
	logic signed [NW-1:0] e_a00, e_a01, e_a11, e_b0, n_b0, n_b1, n_ab0, n_ab1, n_a00b0, n_a01;
	logic signed [NW-1:0] ns, ds, nt, dt;
	logic                 par;

	assign e_a00   = NW'(a00_s5);
	assign e_a01   = NW'(a01_s5);
	assign e_a11   = NW'(a11_s5);
	assign e_b0    = NW'(b0_s5);
	assign n_b0    = -NW'(b0_s5);
	assign n_b1    = -NW'(b1_s5);
	assign n_ab0   = -(NW'(a01_s5) + NW'(b0_s5));
	assign n_ab1   = -(NW'(a01_s5) + NW'(b1_s5));
	assign n_a00b0 = -(NW'(a00_s5) + NW'(b0_s5));
	assign n_a01   = -NW'(a01_s5);
	assign par     = (det_s5 == N_ZERO) || (det_s5 < $signed(NW'(thr_q)));

	always_comb begin
		ns = N_ZERO;
		ds = N_ONE;
		nt = N_ZERO;
		dt = N_ONE;
		if (!par) begin
			if (sn_s5 >= N_ZERO) begin
				if (sn_s5 <= det_s5) begin
					if (tn_s5 >= N_ZERO) begin
						if (tn_s5 <= det_s5) begin
							ns = sn_s5;
							ds = det_s5;
							nt = tn_s5;
							dt = det_s5;
						end else begin
							nt = N_ONE;
							ns = n_ab0;
							ds = e_a00;
						end
					end else begin
						ns = n_b0;
						ds = e_a00;
					end
				end else if (tn_s5 >= N_ZERO) begin
					if (tn_s5 <= det_s5) begin
						ns = N_ONE;
						nt = n_ab1;
						dt = e_a11;
					end else if (n_ab0 <= e_a00) begin
						nt = N_ONE;
						ns = n_ab0;
						ds = e_a00;
					end else begin
						ns = N_ONE;
						nt = n_ab1;
						dt = e_a11;
					end
				end else if (n_b0 < e_a00) begin
					ns = n_b0;
					ds = e_a00;
				end else begin
					ns = N_ONE;
					nt = n_ab1;
					dt = e_a11;
				end
			end else if (tn_s5 >= N_ZERO) begin
				if (tn_s5 <= det_s5) begin
					nt = n_b1;
					dt = e_a11;
				end else if (n_ab0 > N_ZERO) begin
					nt = N_ONE;
					ns = n_ab0;
					ds = e_a00;
				end else begin
					nt = n_b1;
					dt = e_a11;
				end
			end else if (n_b0 > N_ZERO) begin
				ns = n_b0;
				ds = e_a00;
			end else begin
				nt = n_b1;
				dt = e_a11;
			end
		end else if (e_a01 > N_ZERO) begin
			if (e_b0 >= N_ZERO) begin
				ns = N_ZERO;
			end else if (n_b0 <= e_a00) begin
				ns = n_b0;
				ds = e_a00;
			end else begin
				ns = N_ONE;
				nt = n_a00b0;
				dt = e_a01;
			end
		end else begin
			if (n_b0 >= e_a00) begin
				ns = N_ONE;
			end else if (e_b0 <= N_ZERO) begin
				ns = n_b0;
				ds = e_a00;
			end else begin
				nt = e_b0;
				dt = n_a01;
			end
		end
	end

	logic signed [NW-1:0] ns_s6, ds_s6, nt_s6, dt_s6;
	logic                 par_s6;
	geo_t                 geo_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			ns_s6  <= ns;
			ds_s6  <= ds;
			nt_s6  <= nt;
			dt_s6  <= dt;
			par_s6 <= par;
			geo_s6 <= geo_s5;
		end
	end

	// s7: saturate or divide
	logic [UW-1:0] ns_s7, ds_s7, nt_s7, dt_s7;
	side_t         side_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			ns_s7 <= UW'(ns_s6);
			ds_s7 <= UW'(ds_s6);
			nt_s7 <= UW'(nt_s6);
			dt_s7 <= UW'(dt_s6);
			if (ns_s6 <= N_ZERO) side_s7.ks <= FR_ZERO;
			else if (ns_s6 >= ds_s6) side_s7.ks <= FR_ONE;
			else side_s7.ks <= FR_DIV;
			if (nt_s6 <= N_ZERO) side_s7.kt <= FR_ZERO;
			else if (nt_s6 >= dt_s6) side_s7.kt <= FR_ONE;
			else side_s7.kt <= FR_DIV;
			side_s7.par <= par_s6;
			side_s7.geo <= geo_s6;
		end
	end

	// s8..s24: dividers with matching sideband line
	logic [PARAM_W-1:0] qs_raw, qt_raw;
	side_t              side_d [PARAM_W];

	ssd_frac_div #(.W(UW), .QW(PARAM_W)) u_div_s (
		.clk (clk),
		.en  (adv),
		.num (ns_s7),
		.den (ds_s7),
		.quo (qs_raw)
	);

	ssd_frac_div #(.W(UW), .QW(PARAM_W)) u_div_t (
		.clk (clk),
		.en  (adv),
		.num (nt_s7),
		.den (dt_s7),
		.quo (qt_raw)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s7;
			for (int j = 1; j < PARAM_W; j++) side_d[j] <= side_d[j-1];
		end
	end

	// s25: force 0 or 1.0, or round the quotient to nearest, ties up
	function automatic logic [PARAM_W-1:0] round_param(input frac_kind_t kind,
		input logic [PARAM_W-1:0] q);
		logic [PARAM_W:0] sum;
		sum = {1'b0, q} + (PARAM_W+1)'(1);
		case (kind)
			FR_ZERO: round_param = '0;
			FR_ONE:  round_param = Q_ONE;
			FR_DIV:  round_param = sum[PARAM_W:1];
			default: round_param = '0;
		endcase
	endfunction

	logic [PARAM_W-1:0] s_s25, t_s25;
	logic               par_s25;
	geo_t               geo_s25;

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s25   <= round_param(side_d[PARAM_W-1].ks, qs_raw);
			t_s25   <= round_param(side_d[PARAM_W-1].kt, qt_raw);
			par_s25 <= side_d[PARAM_W-1].par;
			geo_s25 <= side_d[PARAM_W-1].geo;
		end
	end

	// s26: parameter times edge vector
	logic signed [SPW-1:0] ps_s26 [3];
	logic signed [SPW-1:0] pt_s26 [3];
	logic signed [DW-1:0]  k_s26 [3];
	logic [PARAM_W-1:0]    s_s26, t_s26;
	logic                  par_s26;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ps_s26[i] <= $signed({1'b0, s_s25}) * signed'(geo_s25.d0[i]);
				pt_s26[i] <= $signed({1'b0, t_s25}) * signed'(geo_s25.d1[i]);
				k_s26[i]  <= signed'(geo_s25.k[i]);
			end
			s_s26   <= s_s25;
			t_s26   <= t_s25;
			par_s26 <= par_s25;
		end
	end

	// s27: separation vector
	logic signed [RW-1:0] r_s27 [3];
	logic [PARAM_W-1:0]   s_s27, t_s27;
	logic                 par_s27;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				r_s27[i] <= (RW'(k_s26[i]) <<< FRAC_BITS) + RW'(ps_s26[i]) - RW'(pt_s26[i]);
			end
			s_s27   <= s_s26;
			t_s27   <= t_s26;
			par_s27 <= par_s26;
		end
	end

	// s28: squares
	logic signed [SQW-1:0] sq_s28 [3];
	logic [PARAM_W-1:0]    s_s28, t_s28;
	logic                  par_s28;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sq_s28[i] <= r_s27[i] * r_s27[i];
			s_s28   <= s_s27;
			t_s28   <= t_s27;
			par_s28 <= par_s27;
		end
	end

	// s29: sum, drop to Q.8, saturate
	logic [SUMW-1:0] sum_sq;
	logic [CMPW-1:0] dist_w;

	assign sum_sq = SUMW'(unsigned'(sq_s28[0])) + SUMW'(unsigned'(sq_s28[1]))
		+ SUMW'(unsigned'(sq_s28[2]));
	assign dist_w = CMPW'(sum_sq[SUMW-1:DIST_SHIFT]);

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_squared <= (dist_w > CMPW'(DIST_MAX)) ? DIST_MAX : DIST_W'(dist_w);
			param_first  <= s_s28;
			param_second <= t_s28;
			parallel     <= par_s28;
		end
	end
endmodule
`default_nettype wire

// ----- design/ssd_chk.sv -----
`default_nettype none
`include "segment_segment_distance_core_macros.svh"
module ssd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic                          pready,
	input logic [ssd_pkg::ADDR_W-1:0]    paddr,
	input logic [ssd_pkg::APB_DW-1:0]    pwdata,
	input logic [ssd_pkg::APB_DW-1:0]    prdata,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ssd_pkg::DIST_W-1:0]    dist_squared,
	input logic [ssd_pkg::PARAM_W-1:0]   param_first,
	input logic [ssd_pkg::PARAM_W-1:0]   param_second,
	input logic                          parallel
);
	import ssd_pkg::*;

	`SSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dist_squared) && $stable(param_first) && $stable(param_second) && $stable(parallel), "stalled result word changed")
	`SSD_ASSERT_SAME(a_stall_source, in_stall, out_valid && out_stall, "input stalled without a stalled result word")
	`SSD_ASSERT_SAME(a_param_range, out_valid, param_first <= Q_ONE && param_second <= Q_ONE, "parameter above 1.0")
	`SSD_ASSERT_NEXT(a_thr_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0]) && (prdata >> THR_W) == '0), "threshold readback mismatch")
endmodule

bind segment_segment_distance_core ssd_chk u_ssd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.pready       (pready),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.dist_squared (dist_squared),
	.param_first  (param_first),
	.param_second (param_second),
	.parallel     (parallel)
);
`default_nettype wire

// ----- tb/tb_segment_segment_distance_core.sv -----
`default_nettype none
module tb_segment_segment_distance_core;
	import ssd_pkg::*;

	localparam int CB = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef logic signed [CB-1:0] coord_t;
	typedef coord_t seg_pair_t [12];

	typedef struct {
		logic [DIST_W-1:0]  dist_sq;
		logic [PARAM_W-1:0] s;
		logic [PARAM_W-1:0] t;
		logic               par;
	} closest_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	seg_pair_t pair;
	logic [DIST_W-1:0] dist_squared;
	logic [PARAM_W-1:0] param_first, param_second;
	logic parallel;

	logic [THR_W-1:0] thr_model = THR_RESET;
	closest_t expected_q[$];
	bit in_gaps = 1, out_gaps = 1;
	int errors = 0, words_in = 0, words_out = 0, par_seen = 0, idle_cycles = 0;

	initial for (int i = 0; i < 12; i++) pair[i] = '0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	segment_segment_distance_core #(.COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_start_x(pair[0]), .first_start_y(pair[1]), .first_start_z(pair[2]),
		.first_end_x(pair[3]), .first_end_y(pair[4]), .first_end_z(pair[5]),
		.second_start_x(pair[6]), .second_start_y(pair[7]), .second_start_z(pair[8]),
		.second_end_x(pair[9]), .second_end_y(pair[10]), .second_end_z(pair[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.dist_squared(dist_squared), .param_first(param_first),
		.param_second(param_second), .parallel(parallel)
	);

	function automatic longint q_ratio(longint num, longint den);
		longint r, q;
		if (den <= 0 || num <= 0) return 0;
		if (num >= den) return 65536;
		r = num;
		q = 0;
		for (int i = 0; i < 17; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic closest_t closest_points(seg_pair_t c, logic [THR_W-1:0] thr);
		longint d0[3], d1[3], k[3];
		longint a00, a01, a11, b0, b1, det, sn, tn, tmp, s, t, r;
		logic [63:0] acc;
		closest_t res;
		bit par;
		a00 = 0; a01 = 0; a11 = 0; b0 = 0; b1 = 0;
		for (int i = 0; i < 3; i++) begin
			d0[i] = longint'(c[3+i]) - longint'(c[i]);
			d1[i] = longint'(c[9+i]) - longint'(c[6+i]);
			k[i] = longint'(c[i]) - longint'(c[6+i]);
			a00 += d0[i] * d0[i];
			a01 -= d0[i] * d1[i];
			a11 += d1[i] * d1[i];
			b0 += k[i] * d0[i];
			b1 -= k[i] * d1[i];
		end
		det = a00 * a11 - a01 * a01;
		if (det < 0) det = -det;
		par = (det == 0) || (det < longint'(thr));
		if (!par) begin
			sn = a01 * b1 - a11 * b0;
			tn = a01 * b0 - a00 * b1;
			if (sn >= 0) begin
				if (sn <= det) begin
					if (tn >= 0) begin
						if (tn <= det) begin
							s = q_ratio(sn, det); t = q_ratio(tn, det);
						end else begin
							t = 65536; s = q_ratio(-(a01 + b0), a00);
						end
					end else begin
						t = 0; s = q_ratio(-b0, a00);
					end
				end else if (tn >= 0) begin
					if (tn <= det) begin
						s = 65536; t = q_ratio(-(a01 + b1), a11);
					end else begin
						tmp = a01 + b0;
						if (-tmp <= a00) begin
							t = 65536; s = q_ratio(-tmp, a00);
						end else begin
							s = 65536; t = q_ratio(-(a01 + b1), a11);
						end
					end
				end else if (-b0 < a00) begin
					t = 0; s = q_ratio(-b0, a00);
				end else begin
					s = 65536; t = q_ratio(-(a01 + b1), a11);
				end
			end else if (tn >= 0) begin
				if (tn <= det) begin
					s = 0; t = q_ratio(-b1, a11);
				end else begin
					tmp = a01 + b0;
					if (tmp < 0) begin
						t = 65536; s = q_ratio(-tmp, a00);
					end else begin
						s = 0; t = q_ratio(-b1, a11);
					end
				end
			end else if (b0 < 0) begin
				t = 0; s = q_ratio(-b0, a00);
			end else begin
				s = 0; t = q_ratio(-b1, a11);
			end
		end else if (a01 > 0) begin
			if (b0 >= 0) begin
				s = 0; t = 0;
			end else if (-b0 <= a00) begin
				s = q_ratio(-b0, a00); t = 0;
			end else begin
				s = 65536; t = q_ratio(-(a00 + b0), a01);
			end
		end else begin
			if (-b0 >= a00) begin
				s = 65536; t = 0;
			end else if (b0 <= 0) begin
				s = q_ratio(-b0, a00); t = 0;
			end else begin
				s = 0;
				t = (b0 >= -a01) ? 65536 : q_ratio(b0, -a01);
			end
		end
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			r = k[i] * 65536 + s * d0[i] - t * d1[i];
			acc += 64'(r * r);
		end
		acc = acc >> 24;
		res.dist_sq = (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
		res.s = s[PARAM_W-1:0];
		res.t = t[PARAM_W-1:0];
		res.par = par;
		return res;
	endfunction

	always @(negedge clk) out_stall <= out_gaps && ($urandom_range(99) < 37);

	always @(posedge clk) begin
		closest_t e;
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (dist_squared !== e.dist_sq) begin
					$error("dist_squared exp %0d got %0d", e.dist_sq, dist_squared); errors++;
				end
				if (param_first !== e.s) begin
					$error("param_first exp %0d got %0d", e.s, param_first); errors++;
				end
				if (param_second !== e.t) begin
					$error("param_second exp %0d got %0d", e.t, param_second); errors++;
				end
				if (parallel !== e.par) begin
					$error("parallel exp %0d got %0d", e.par, parallel); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("segment_segment_distance_core verification failed");
			$finish;
		end
	end

	task automatic send_pair(seg_pair_t c);
		while (in_gaps && $urandom_range(99) < 37) begin
			in_valid = 0;
			@(negedge clk);
		end
		pair = c;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(closest_points(c, thr_model));
		if (expected_q[$].par) par_seen++;
		words_in++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		drain();
		paddr = {REG_DET_THR, 2'b00};
		pwdata = APB_DW'(v);
		pwrite = 1;
		psel = 1;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		thr_model = v;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		@(negedge clk);
		psel = 1;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		if (prdata[THR_W-1:0] !== v) begin
			$error("det_threshold exp %0d got %0d", v, prdata[THR_W-1:0]); errors++;
		end
		@(negedge clk);
		psel = 0; penable = 0;
	endtask

	function automatic seg_pair_t make_pair(int p[12]);
		seg_pair_t c;
		for (int i = 0; i < 12; i++) c[i] = coord_t'(p[i]);
		return c;
	endfunction

	function automatic coord_t rand_coord(int span);
		return coord_t'($urandom_range(2 * span) - span);
	endfunction

	function automatic seg_pair_t rand_pair(int span);
		seg_pair_t c;
		for (int i = 0; i < 12; i++) c[i] = rand_coord(span);
		return c;
	endfunction

	// second segment lies along a scaled copy of the first direction
	function automatic seg_pair_t rand_parallel_pair();
		seg_pair_t c;
		int d, m, o;
		m = $urandom_range(4) - 2;
		for (int i = 0; i < 3; i++) begin
			d = $urandom_range(200) - 100;
			o = $urandom_range(1200) - 600;
			c[i] = rand_coord(500);
			c[3+i] = coord_t'(int'(c[i]) + d);
			c[6+i] = coord_t'(int'(c[i]) + o);
			c[9+i] = coord_t'(int'(c[i]) + o + m * d);
		end
		return c;
	endfunction

	task automatic test_directed();
		send_pair(make_pair('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
		send_pair(make_pair('{-2048,-2048,-2048, 2047,2047,2047,
			2047,2047,2047, -2048,-2048,-2048}));
		send_pair(make_pair('{-2048,-2048,-2048, -2048,-2048,-2048,
			2047,2047,2047, 2047,2047,2047}));
		send_pair(make_pair('{-2048,2047,-2048, 2047,-2048,2047,
			-2048,-2048,2047, 2047,2047,-2048}));
		send_pair(make_pair('{5,5,5, 5,5,5, 0,0,0, 10,0,0}));
		send_pair(make_pair('{0,0,0, 10,0,0, 3,3,3, 3,3,3}));
		send_pair(make_pair('{-10,0,0, 10,0,0, 0,-10,5, 0,10,5}));
		send_pair(make_pair('{0,0,0, 10,0,0, 2,0,3, 8,0,3}));
		send_pair(make_pair('{0,0,0, 10,0,0, 8,0,3, 2,0,3}));
		send_pair(make_pair('{0,0,0, 10,0,0, 20,0,3, 30,0,3}));
		send_pair(make_pair('{0,0,0, 10,0,0, -20,0,3, -30,0,3}));
		send_pair(make_pair('{0,0,0, 10,0,0, 20,-5,1, 20,5,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, -20,-5,1, -20,5,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, 5,20,1, 5,30,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, 5,-20,1, 5,-30,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, 20,20,1, 30,30,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, -20,-20,1, -30,-40,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, 20,-20,1, 40,-30,1}));
		send_pair(make_pair('{0,0,0, 10,0,0, -20,20,1, -30,40,1}));
		send_pair(make_pair('{0,0,0, 3,0,0, 0,1,0, 1,1,0}));
		send_pair(make_pair('{0,0,0, 3,1,0, 0,1,0, 1,1,0}));
		send_pair(make_pair('{1,2,3, 1,2,3, 1,2,3, 1,2,3}));
	endtask

	task automatic test_threshold_extremes();
		write_threshold('0);
		for (int i = 0; i < 8; i++) send_pair(rand_parallel_pair());
		send_pair(make_pair('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
		send_pair(make_pair('{0,0,0, 3,1,0, 0,1,0, 1,1,0}));
		write_threshold(THR_W'(1048576));
		for (int i = 0; i < 20; i++) send_pair(rand_pair(40));
		write_threshold('1);
		for (int i = 0; i < 10; i++) send_pair(rand_pair(60));
	endtask

	task automatic test_random();
		int sel;
		for (int ph = 0; ph < 4; ph++) begin
			write_threshold(ph == 0 ? THR_RESET : THR_W'($urandom_range(1048576)));
			in_gaps = (ph != 2);
			out_gaps = (ph != 2);
			for (int i = 0; i < 190; i++) begin
				sel = $urandom_range(9);
				if (sel < 5) send_pair(rand_pair(2048));
				else if (sel < 8) send_pair(rand_pair($urandom_range(1, 50)));
				else send_pair(rand_parallel_pair());
			end
		end
		in_gaps = 1;
		out_gaps = 1;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_threshold_extremes();
		test_random();
		drain();
		$display("Sent %0d segment pairs, checked %0d results (%0d parallel) over",
			words_in, words_out, par_seen);
		$display("several det_threshold settings including 0, 1 and full scale.");
		if (errors == 0)
			$display("segment_segment_distance_core verification clean");
		else
			$display("segment_segment_distance_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- segment_segment_distance_core.f -----
+incdir+design
design/ssd_pkg.sv
design/ssd_frac_div.sv
design/segment_segment_distance_core.sv
design/ssd_chk.sv
tb/tb_segment_segment_distance_core.sv
